// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL, used by the sequencer.
// Define ASSERT_OFF to compile all checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/tgcl_pkg.sv =====
`timescale 1ns / 1ps

package tgcl_pkg;

    // Field widths of the stream words
    localparam int IDX_W       = 4;
    localparam int GATE_W      = 8;
    localparam int DUR_IN_W    = 32;
    localparam int LEN_W       = 5;
    localparam int ADV_W       = 16;
    localparam int DELAY_W     = 32;
    localparam int ENTRY_W     = 4;
    localparam int MODE_W      = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Operation carried in the input tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_COMMIT = 2'd2
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPRESS_MASK = 2'd0,
        CFG_HOLD_REL_EN  = 2'd1,
        CFG_HOLD_ADVANCE = 2'd2
    } t_cfg_idx;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [GATE_W-1:0] express_mask;
        logic              hold_rel_en;
        logic [ADV_W-1:0]  hold_advance;
    } t_cfg;

    // Sequencer to list store controls
    typedef struct packed {
        logic wr_en;    // write one pending entry
        logic advance;  // rotate the active ring by one entry
        logic swap;     // take the pending list as the new active list
    } t_store_ctl;

endpackage

// ===== hw/rtl/tgcl_list_store.sv =====
`timescale 1ns / 1ps

module tgcl_list_store #(
    parameter int LIST_DEPTH    = 16,
    parameter int GATE_COUNT    = 8,
    parameter int DURATION_BITS = 32
) (
    input  logic                                i_clk,
    input  tgcl_pkg::t_store_ctl                i_ctl,
    input  logic [tgcl_pkg::IDX_W-1:0]          i_wr_idx,
    input  logic [tgcl_pkg::GATE_W-1:0]         i_wr_gates,
    input  logic [tgcl_pkg::DUR_IN_W-1:0]       i_wr_dur,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]     i_rot_cnt,
    output logic [tgcl_pkg::GATE_W-1:0]         o_cur_gates,
    output logic [DURATION_BITS-1:0]            o_cur_dur,
    output logic [tgcl_pkg::GATE_W-1:0]         o_next_gates,
    output logic [tgcl_pkg::GATE_W-1:0]         o_pend0_gates
);
    import tgcl_pkg::*;

    localparam logic [GATE_W-1:0] GMASK = GATE_W'((1 << GATE_COUNT) - 1);

    // Pending list in entry order; active list as a ring whose head is the current entry
    logic [GATE_W-1:0]        r_pend_gates [LIST_DEPTH];
    logic [DURATION_BITS-1:0] r_pend_dur   [LIST_DEPTH];
    logic [GATE_W-1:0]        r_ring_gates [LIST_DEPTH];
    logic [DURATION_BITS-1:0] r_ring_dur   [LIST_DEPTH];

    logic [GATE_W-1:0]        src_gates    [LIST_DEPTH];
    logic [DURATION_BITS-1:0] src_dur      [LIST_DEPTH];
    logic [GATE_W-1:0]        n_ring_gates [LIST_DEPTH];
    logic [DURATION_BITS-1:0] n_ring_dur   [LIST_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_entry
            // Pick the list this step works from
            assign src_gates[gi] = i_ctl.swap ? r_pend_gates[gi] : r_ring_gates[gi];
            assign src_dur[gi]   = i_ctl.swap ? r_pend_dur[gi]   : r_ring_dur[gi];

            // Rotate by one; the head wraps into the slot of the last valid entry
            if (gi < LIST_DEPTH - 1) begin : g_mid
                assign n_ring_gates[gi] = (gi + 1 >= int'(i_rot_cnt)) ? src_gates[0]
                                                                      : src_gates[gi+1];
                assign n_ring_dur[gi]   = (gi + 1 >= int'(i_rot_cnt)) ? src_dur[0]
                                                                      : src_dur[gi+1];
            end else begin : g_end
                assign n_ring_gates[gi] = src_gates[0];
                assign n_ring_dur[gi]   = src_dur[0];
            end

            // Write pending entries, advance the ring on each entry step
            always_ff @(posedge i_clk) begin
                if (i_ctl.wr_en && (int'(i_wr_idx) == gi)) begin
                    r_pend_gates[gi] <= i_wr_gates & GMASK;
                    r_pend_dur[gi]   <= DURATION_BITS'(i_wr_dur);
                end
                if (i_ctl.advance) begin
                    r_ring_gates[gi] <= n_ring_gates[gi];
                    r_ring_dur[gi]   <= n_ring_dur[gi];
                end
            end
        end

        // Entry following the current one, wrapping on a single entry list
        if (LIST_DEPTH > 1) begin : g_next
            assign o_next_gates = (int'(i_rot_cnt) > 1) ? src_gates[1] : src_gates[0];
        end else begin : g_next_one
            assign o_next_gates = src_gates[0];
        end
    endgenerate

    assign o_cur_gates   = src_gates[0];
    assign o_cur_dur     = src_dur[0];
    assign o_pend0_gates = r_pend_gates[0];

endmodule

// ===== hw/rtl/tgcl_sched.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgcl_sched #(
    parameter int LIST_DEPTH    = 16,
    parameter int GATE_COUNT    = 8,
    parameter int DURATION_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Word from the input register
    input  logic                                i_fire,
    input  tgcl_pkg::t_mode                     i_mode,
    input  logic [tgcl_pkg::LEN_W-1:0]          i_list_length,
    input  logic                                i_mac_on_hold,
    input  tgcl_pkg::t_cfg                      i_cfg,
    // List store
    output tgcl_pkg::t_store_ctl                o_store_ctl,
    output logic [$clog2(LIST_DEPTH+1)-1:0]     o_rot_cnt,
    input  logic [tgcl_pkg::GATE_W-1:0]         i_cur_gates,
    input  logic [DURATION_BITS-1:0]            i_cur_dur,
    input  logic [tgcl_pkg::GATE_W-1:0]         i_next_gates,
    input  logic [tgcl_pkg::GATE_W-1:0]         i_pend0_gates,
    // Result register
    output logic                                o_can_accept,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tgcl_pkg::GATE_W-1:0]         o_gate_states,
    output logic                                o_gates_updated,
    output logic                                o_release_res,
    output logic                                o_hold_request,
    output logic [tgcl_pkg::DELAY_W-1:0]        o_hold_delay,
    output logic [tgcl_pkg::ENTRY_W-1:0]        o_current_entry
);
    import tgcl_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int PTR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int DW    = ((DURATION_BITS > ADV_W) ? DURATION_BITS : ADV_W) + 1;
    localparam logic [GATE_W-1:0] GMASK = GATE_W'((1 << GATE_COUNT) - 1);

    // Sequencer state
    logic [CNT_W-1:0]         r_act_cnt,  n_act_cnt;
    logic [CNT_W-1:0]         r_pend_cnt, n_pend_cnt;
    logic                     r_pend_valid, n_pend_valid;
    logic [PTR_W-1:0]         r_ptr, n_ptr;
    logic [DURATION_BITS-1:0] r_ticks, n_ticks;
    logic                     r_running, n_running;
    logic [GATE_W-1:0]        r_gates, n_gates;
    logic                     r_out_valid, n_out_valid;

    // Result payload
    logic [GATE_W-1:0]  r_res_gates;
    logic               r_res_upd, n_res_upd;
    logic               r_res_rel, n_res_rel;
    logic               r_res_hold, n_res_hold;
    logic [DELAY_W-1:0] r_res_delay, n_res_delay;
    logic [ENTRY_W-1:0] r_res_entry, n_res_entry;

    logic             tick, countdown, do_step, swap, empty, apply, last, pv_after;
    logic [CNT_W-1:0] cnt, len_sat;
    logic [GATE_W-1:0] next_gates;
    logic             rel, hold;
    logic [DW-1:0]    dly_diff;
    logic [DELAY_W-1:0] dly;

    assign o_can_accept = !r_out_valid || i_out_ready;

    // Decode what this word does to the schedule
    always_comb begin
        tick      = i_fire && (i_mode == MODE_TICK);
        countdown = tick && r_running && (r_ticks > DURATION_BITS'(1));
        do_step   = tick && !countdown && (r_running || r_pend_valid);
        swap      = do_step && (r_ptr == '0) && r_pend_valid;
        cnt       = swap ? r_pend_cnt : r_act_cnt;
        empty     = swap && (r_pend_cnt == '0);
        apply     = do_step && !empty;
        pv_after  = r_pend_valid && !swap;
        last      = (CNT_W'(r_ptr) + CNT_W'(1)) == cnt;
        len_sat   = (int'(i_list_length) > LIST_DEPTH) ? CNT_W'(LIST_DEPTH)
                                                       : CNT_W'(i_list_length);
    end

    // Gate mask of the entry after this one, and the hold and release terms
    always_comb begin
        if (pv_after && last) begin
            next_gates = (r_pend_cnt != '0) ? i_pend0_gates : '0;
        end else begin
            next_gates = i_next_gates;
        end
        rel      = i_cfg.hold_rel_en && ((i_cur_gates & i_cfg.express_mask & GMASK) == '0)
                   && i_mac_on_hold;
        hold     = i_cfg.hold_rel_en && ((next_gates & i_cfg.express_mask & GMASK) != '0);
        dly_diff = DW'(i_cur_dur) - DW'(i_cfg.hold_advance);
        dly      = (!dly_diff[DW-1] && (dly_diff != '0)) ? DELAY_W'(dly_diff[DW-2:0]) : '0;
    end

    // Store controls
    always_comb begin
        o_store_ctl.wr_en   = i_fire && (i_mode == MODE_WRITE);
        o_store_ctl.advance = apply;
        o_store_ctl.swap    = swap;
        o_rot_cnt           = cnt;
    end

    // Next sequencer state
    always_comb begin
        n_act_cnt    = r_act_cnt;
        n_pend_cnt   = r_pend_cnt;
        n_pend_valid = r_pend_valid;
        n_ptr        = r_ptr;
        n_ticks      = r_ticks;
        n_running    = r_running;
        n_gates      = r_gates;
        if (i_fire) begin
            case (i_mode)
                MODE_TICK: begin
                    if (countdown) begin
                        n_ticks = r_ticks - DURATION_BITS'(1);
                    end else if (empty) begin
                        n_act_cnt    = '0;
                        n_pend_valid = 1'b0;
                        n_running    = 1'b0;
                        n_ptr        = '0;
                        n_ticks      = '0;
                        n_gates      = GMASK;
                    end else if (apply) begin
                        if (swap) begin
                            n_act_cnt    = r_pend_cnt;
                            n_pend_valid = 1'b0;
                        end
                        n_running = 1'b1;
                        n_gates   = i_cur_gates;
                        n_ticks   = i_cur_dur;
                        n_ptr     = last ? '0 : r_ptr + PTR_W'(1);
                    end
                end
                MODE_COMMIT: begin
                    n_pend_cnt   = len_sat;
                    n_pend_valid = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result word
    always_comb begin
        n_res_upd   = do_step;
        n_res_rel   = empty || (apply && rel);
        n_res_hold  = apply && hold;
        n_res_delay = (apply && hold) ? dly : '0;
        n_res_entry = apply ? ENTRY_W'(r_ptr) : '0;
        if (i_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_cnt    <= '0;
            r_pend_cnt   <= '0;
            r_pend_valid <= 1'b0;
            r_ptr        <= '0;
            r_ticks      <= '0;
            r_running    <= 1'b0;
            r_gates      <= GMASK;
            r_out_valid  <= 1'b0;
        end else begin
            r_act_cnt    <= n_act_cnt;
            r_pend_cnt   <= n_pend_cnt;
            r_pend_valid <= n_pend_valid;
            r_ptr        <= n_ptr;
            r_ticks      <= n_ticks;
            r_running    <= n_running;
            r_gates      <= n_gates;
            r_out_valid  <= n_out_valid;
        end
    end

    // Load the result word with each processed input word
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res_gates <= n_gates;
            r_res_upd   <= n_res_upd;
            r_res_rel   <= n_res_rel;
            r_res_hold  <= n_res_hold;
            r_res_delay <= n_res_delay;
            r_res_entry <= n_res_entry;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_gate_states   = r_res_gates;
    assign o_gates_updated = r_res_upd;
    assign o_release_res   = r_res_rel;
    assign o_hold_request  = r_res_hold;
    assign o_hold_delay    = r_res_delay;
    assign o_current_entry = r_res_entry;

    // A running schedule always has entries and points inside them
    `ASSERT_CLK(a_run_has_entries, i_clk, i_rst_n, r_running |-> (r_act_cnt != '0), "running with empty list")
    `ASSERT_CLK(a_ptr_in_list, i_clk, i_rst_n, r_running |-> (CNT_W'(r_ptr) < r_act_cnt), "entry pointer past list end")
    // An idle schedule holds no countdown
    `ASSERT_NEVER(a_idle_no_ticks, i_clk, i_rst_n, !r_running && (r_ticks != '0), "countdown while idle")
    // A hold request only comes with an entry step
    `ASSERT_CLK(a_hold_with_step, i_clk, i_rst_n, (r_out_valid && r_res_hold) |-> r_res_upd, "hold without entry step")
    // A commit leaves a pending list behind
    `ASSERT_CLK(a_commit_pending, i_clk, i_rst_n, (i_fire && (i_mode == MODE_COMMIT)) |=> r_pend_valid, "commit lost")

endmodule

// ===== hw/rtl/tsn_gate_control_list_sequencer_core.sv =====
`timescale 1ns / 1ps
// Time-aware gate sequencer with a pending and an active gate control list.
// Input stream: s_axis_tuser selects the operation (tick, write pending entry,
// commit pending list); s_axis_tdata carries the entry and MAC hold fields.
// Output stream: one word per input word with the current gate mask, the
// hold/release flags, the hold delay and the applied entry; m_axis_tuser
// flags words on which an entry step happened.
// Configuration: i_cfg_* writes express mask, hold/release enable and hold
// advance; always ready, to be written only while the block is idle.
// Path: an accepted word is held in the input register, then loaded into the
// result register. Throughput: one word per cycle unless the output stalls;
// an input register and a result register with one pass of compare,
// subtract and select between them.
// Reset: gates all open, no list running, nothing pending, configuration zero;
// list contents are undefined until written.
// Stall: when m_axis_tready is low the result word holds; an empty input
// register still takes one word, then s_axis_tready stays low until the
// result is taken.
module tsn_gate_control_list_sequencer_core #(
    parameter int LIST_DEPTH    = 16,
    parameter int GATE_COUNT    = 8,
    parameter int DURATION_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tgcl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tgcl_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // entry_index[3:0], entry_gates[11:4], entry_duration[43:12],
    // list_length[48:44], mac_on_hold[49], zero[55:50]
    input  logic [tgcl_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // mode[1:0]
    input  logic [tgcl_pkg::MODE_W-1:0]           s_axis_tuser,
    // Output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // gate_states[7:0], release_res[8], hold_request[9], hold_delay[41:10],
    // current_entry[45:42], zero[47:46]
    output logic [tgcl_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // gates_updated[0]
    output logic [0:0]                            m_axis_tuser
);
    import tgcl_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    t_cfg                   r_cfg;
    logic                   r_in_valid;
    logic [IN_TDATA_W-1:0]  r_in_tdata;
    logic [MODE_W-1:0]      r_in_tuser;

    logic                   can_accept, fire;
    t_store_ctl             store_ctl;
    logic [CNT_W-1:0]       rot_cnt;
    logic [GATE_W-1:0]      cur_gates, next_gates, pend0_gates;
    logic [DURATION_BITS-1:0] cur_dur;

    logic [GATE_W-1:0]      gate_states;
    logic                   gates_updated, release_res, hold_request;
    logic [DELAY_W-1:0]     hold_delay;
    logic [ENTRY_W-1:0]     current_entry;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_EXPRESS_MASK: r_cfg.express_mask <= i_cfg_data[GATE_W-1:0];
                CFG_HOLD_REL_EN:  r_cfg.hold_rel_en  <= i_cfg_data[0];
                CFG_HOLD_ADVANCE: r_cfg.hold_advance <= i_cfg_data[ADV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: take a word when empty or when the held one moves on
    assign fire          = r_in_valid && can_accept;
    assign s_axis_tready = !r_in_valid || can_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_tdata <= s_axis_tdata;
            r_in_tuser <= s_axis_tuser;
        end
    end

    tgcl_list_store #(
        .LIST_DEPTH    (LIST_DEPTH),
        .GATE_COUNT    (GATE_COUNT),
        .DURATION_BITS (DURATION_BITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_ctl         (store_ctl),
        .i_wr_idx      (r_in_tdata[3:0]),
        .i_wr_gates    (r_in_tdata[11:4]),
        .i_wr_dur      (r_in_tdata[43:12]),
        .i_rot_cnt     (rot_cnt),
        .o_cur_gates   (cur_gates),
        .o_cur_dur     (cur_dur),
        .o_next_gates  (next_gates),
        .o_pend0_gates (pend0_gates)
    );

    tgcl_sched #(
        .LIST_DEPTH    (LIST_DEPTH),
        .GATE_COUNT    (GATE_COUNT),
        .DURATION_BITS (DURATION_BITS)
    ) u_sched (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_mode          (t_mode'(r_in_tuser)),
        .i_list_length   (r_in_tdata[48:44]),
        .i_mac_on_hold   (r_in_tdata[49]),
        .i_cfg           (r_cfg),
        .o_store_ctl     (store_ctl),
        .o_rot_cnt       (rot_cnt),
        .i_cur_gates     (cur_gates),
        .i_cur_dur       (cur_dur),
        .i_next_gates    (next_gates),
        .i_pend0_gates   (pend0_gates),
        .o_can_accept    (can_accept),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_gate_states   (gate_states),
        .o_gates_updated (gates_updated),
        .o_release_res   (release_res),
        .o_hold_request  (hold_request),
        .o_hold_delay    (hold_delay),
        .o_current_entry (current_entry)
    );

    // Pack the result word
    assign m_axis_tdata = {2'b00, current_entry, hold_delay, hold_request, release_res,
                           gate_states};
    assign m_axis_tuser = gates_updated;

endmodule

// ===== verif/tsn_gate_control_list_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module tsn_gate_control_list_sequencer_core_tb;
    import tgcl_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RX_LONG_HOLD = 300;
    // Random traffic never commits a list holding an entry longer than this
    localparam int DUR_SAFE = 64;
    // Mode code the block has no operation for
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [IDX_W-1:0]    idx;
        logic [GATE_W-1:0]   gates;
        logic [DUR_IN_W-1:0] dur;
        logic [LEN_W-1:0]    len;
        logic                mac;
    } t_sched_cmd;

    typedef struct packed {
        logic [GATE_W-1:0]  gates;
        logic               upd;
        logic               rel;
        logic               hold;
        logic [DELAY_W-1:0] delay;
        logic [ENTRY_W-1:0] entry;
    } t_gate_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_EXPRESS_MASK;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [MODE_W-1:0]      s_axis_tuser = MODE_TICK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    tsn_gate_control_list_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Pending commands and expected gate words
    t_sched_cmd sched_cmd_q[$];
    t_gate_word gate_word_q[$];
    int cmds_pushed = 0;
    int cmds_taken = 0;
    int words_seen = 0;
    int err_cnt = 0;

    // Idle pacing, set per phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_long_arm = 1'b0;

    // Predicted configuration
    logic [GATE_W-1:0] cfg_express = '0;
    logic              cfg_hold_en = 1'b0;
    logic [ADV_W-1:0]  cfg_advance = '0;

    // Predicted schedule state
    logic [GATE_W-1:0]   sch_act_gates[LIST_DEPTH];
    logic [DUR_IN_W-1:0] sch_act_dur[LIST_DEPTH];
    logic [GATE_W-1:0]   sch_pend_gates[LIST_DEPTH];
    logic [DUR_IN_W-1:0] sch_pend_dur[LIST_DEPTH];
    int                  sch_act_cnt = 0;
    int                  sch_pend_cnt = 0;
    bit                  sch_pend_ok = 1'b0;
    int                  sch_ptr = 0;
    logic [DUR_IN_W-1:0] sch_ticks = '0;
    bit                  sch_run = 1'b0;
    logic [GATE_W-1:0]   sch_gate_reg = '1;

    // Stimulus bookkeeping: which pending entries are written, and with a long duration
    bit gen_written[LIST_DEPTH];
    bit gen_big[LIST_DEPTH];
    int gen_pend_len = 0;

    // Work out the gate word one command causes and advance the schedule
    function automatic t_gate_word sched_predict(input t_sched_cmd c);
        t_gate_word r;
        int idx;
        logic [GATE_W-1:0] nxt;
        r = '0;
        if (c.mode == MODE_TICK) begin
            if (sch_run && sch_ticks > 1) begin
                sch_ticks = sch_ticks - 1;
            end else if (sch_run || sch_pend_ok) begin
                if (!sch_run)
                    sch_ptr = 0;
                // Swap in a committed list at the head of the cycle
                if (sch_ptr == 0 && sch_pend_ok) begin
                    sch_act_gates = sch_pend_gates;
                    sch_act_dur = sch_pend_dur;
                    sch_act_cnt = sch_pend_cnt;
                    sch_pend_ok = 1'b0;
                end
                if (sch_act_cnt == 0) begin
                    // Empty list: open all gates and stop
                    sch_run = 1'b0;
                    sch_ptr = 0;
                    sch_ticks = '0;
                    sch_gate_reg = '1;
                    r.upd = 1'b1;
                    r.rel = 1'b1;
                end else begin
                    sch_run = 1'b1;
                    idx = sch_ptr;
                    sch_gate_reg = sch_act_gates[idx];
                    sch_ticks = sch_act_dur[idx];
                    r.upd = 1'b1;
                    r.entry = ENTRY_W'(idx);
                    if (cfg_hold_en) begin
                        r.rel = ((sch_gate_reg & cfg_express) == '0) && c.mac;
                        // Look ahead into the pending list at the end of the cycle
                        if (sch_pend_ok && idx == sch_act_cnt - 1)
                            nxt = (sch_pend_cnt != 0) ? sch_pend_gates[0] : '0;
                        else
                            nxt = sch_act_gates[(idx + 1) % sch_act_cnt];
                        if ((nxt & cfg_express) != '0) begin
                            r.hold = 1'b1;
                            r.delay = (sch_ticks > cfg_advance) ? sch_ticks - cfg_advance : '0;
                        end
                    end
                    sch_ptr = (idx + 1) % sch_act_cnt;
                end
            end
        end else if (c.mode == MODE_WRITE) begin
            sch_pend_gates[c.idx] = c.gates;
            sch_pend_dur[c.idx] = c.dur;
        end else if (c.mode == MODE_COMMIT) begin
            sch_pend_cnt = (c.len > LIST_DEPTH) ? LIST_DEPTH : int'(c.len);
            sch_pend_ok = 1'b1;
        end
        r.gates = sch_gate_reg;
        return r;
    endfunction

    // Stall length: mostly short, now and then long
    function automatic int pick_stall_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Input side: offer queued commands, predict on each accepted word
    t_sched_cmd drv_cmd;
    bit         drv_busy;
    int         tx_gap_left = 0;

    always @(posedge i_clk) begin
        drv_busy = s_axis_tvalid;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                gate_word_q.insert(gate_word_q.size(), sched_predict(drv_cmd));
                cmds_taken++;
                drv_busy = 1'b0;
                if ($urandom_range(0, 99) < tx_idle_pct)
                    tx_gap_left = pick_stall_len();
            end
            if (!drv_busy) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                end else if (sched_cmd_q.size() > 0) begin
                    drv_cmd = sched_cmd_q.pop_front();
                    drv_busy = 1'b1;
                    s_axis_tdata <= {6'b0, drv_cmd.mac, drv_cmd.len, drv_cmd.dur,
                                     drv_cmd.gates, drv_cmd.idx};
                    s_axis_tuser <= drv_cmd.mode;
                end
            end
        end
        s_axis_tvalid <= drv_busy;
    end

    // Output side: check each accepted word, pace tready
    t_gate_word mon_got;
    t_gate_word mon_want;
    bit         rx_rdy;
    bit         rx_long_done = 1'b0;
    int         rx_hold_left = 0;
    int         rx_gap_left = 0;

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            mon_got.gates = m_axis_tdata[7:0];
            mon_got.rel = m_axis_tdata[8];
            mon_got.hold = m_axis_tdata[9];
            mon_got.delay = m_axis_tdata[41:10];
            mon_got.entry = m_axis_tdata[45:42];
            mon_got.upd = m_axis_tuser[0];
            if (gate_word_q.size() == 0) begin
                if (err_cnt < 10)
                    $display("gate word %0d arrived with nothing expected: %h/%b",
                             words_seen, m_axis_tdata, m_axis_tuser);
                err_cnt++;
            end else begin
                mon_want = gate_word_q.pop_front();
                if (mon_got.gates !== mon_want.gates || mon_got.upd !== mon_want.upd ||
                    mon_got.rel !== mon_want.rel || mon_got.hold !== mon_want.hold ||
                    mon_got.delay !== mon_want.delay || mon_got.entry !== mon_want.entry) begin
                    if (err_cnt < 10) begin
                        $display("gate word %0d mismatch at %0t:", words_seen, $realtime);
                        $display("  exp gates=%h upd=%b rel=%b hold=%b delay=%h entry=%0d",
                                 mon_want.gates, mon_want.upd, mon_want.rel, mon_want.hold,
                                 mon_want.delay, mon_want.entry);
                        $display("  got gates=%h upd=%b rel=%b hold=%b delay=%h entry=%0d",
                                 mon_got.gates, mon_got.upd, mon_got.rel, mon_got.hold,
                                 mon_got.delay, mon_got.entry);
                    end
                    err_cnt++;
                end
            end
            words_seen++;
        end

        // Hold tready low for a long stretch once, otherwise random gaps
        if (!i_rst_n) begin
            rx_rdy = 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            rx_rdy = 1'b0;
        end else if (rx_long_arm && !rx_long_done) begin
            rx_long_done = 1'b1;
            rx_hold_left = RX_LONG_HOLD;
            rx_rdy = 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            rx_rdy = 1'b0;
        end else begin
            rx_rdy = 1'b1;
            if ($urandom_range(0, 99) < rx_idle_pct)
                rx_gap_left = pick_stall_len();
        end
        m_axis_tready <= rx_rdy;
    end

    // Abort when nothing moves for too long
    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tsn_gate_control_list_sequencer_core_tb: errors");
            $finish;
        end
    end

    task automatic push_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                             input logic [GATE_W-1:0] gates, input logic [DUR_IN_W-1:0] dur,
                             input logic [LEN_W-1:0] len, input logic mac);
        t_sched_cmd c;
        c.mode = mode;
        c.idx = idx;
        c.gates = gates;
        c.dur = dur;
        c.len = len;
        c.mac = mac;
        sched_cmd_q.insert(sched_cmd_q.size(), c);
        cmds_pushed++;
        if (mode == MODE_WRITE) begin
            gen_written[idx] = 1'b1;
            gen_big[idx] = (dur > DUR_SAFE);
        end else if (mode == MODE_COMMIT) begin
            gen_pend_len = (len > LIST_DEPTH) ? LIST_DEPTH : int'(len);
        end
    endtask

    // Ticks carry random content in every unused field
    task automatic push_ticks(input int n);
        repeat (n) push_item(MODE_TICK, IDX_W'($urandom), GATE_W'($urandom), $urandom,
                             LEN_W'($urandom), 1'($urandom));
    endtask

    // A commit may only name entries that are written and short
    function automatic bit list_ok(input logic [LEN_W-1:0] len);
        int m;
        m = (len > LIST_DEPTH) ? LIST_DEPTH : int'(len);
        for (int i = 0; i < m; i++)
            if (!gen_written[i] || gen_big[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_EXPRESS_MASK: cfg_express = data[GATE_W-1:0];
            CFG_HOLD_REL_EN:  cfg_hold_en = data[0];
            CFG_HOLD_ADVANCE: cfg_advance = data[ADV_W-1:0];
            default: ;
        endcase
    endtask

    // Write all three registers, with junk in the bits above the mask and the enable
    task automatic set_config(input logic [GATE_W-1:0] mask, input logic en,
                              input logic [ADV_W-1:0] adv);
        logic [31:0] junk;
        junk = $urandom;
        cfg_write(CFG_EXPRESS_MASK, {junk[15:8], mask});
        cfg_write(CFG_HOLD_REL_EN, {junk[30:16], en});
        cfg_write(CFG_HOLD_ADVANCE, adv);
    endtask

    // Wait until every command is taken and every gate word checked
    task automatic drain();
        do @(posedge i_clk);
        while (cmds_taken != cmds_pushed || gate_word_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Random schedule traffic: mostly well-formed lists with ticks, some noise
    task automatic run_phase(input int n);
        int start;
        int r;
        int len;
        int i;
        logic [DUR_IN_W-1:0] d;
        logic [IDX_W-1:0]    ix;
        logic [LEN_W-1:0]    cl;
        logic [MODE_W-1:0]   md;
        start = cmds_pushed;
        while (cmds_pushed - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // Well-formed: write entries, commit, then tick
                r = $urandom_range(0, 19);
                len = (r == 0) ? 0 : (r < 3) ? LIST_DEPTH : $urandom_range(1, 6);
                for (i = 0; i < len; i++) begin
                    d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12)
                                                     : $urandom_range(1, 3);
                    push_item(MODE_WRITE, IDX_W'(i), GATE_W'($urandom), d,
                              LEN_W'($urandom), 1'($urandom));
                end
                cl = (len == LIST_DEPTH && $urandom_range(0, 1)) ?
                     LEN_W'($urandom_range(LIST_DEPTH + 1, 31)) : LEN_W'(len);
                push_item(MODE_COMMIT, IDX_W'($urandom), GATE_W'($urandom), $urandom, cl,
                          1'($urandom));
                push_ticks($urandom_range(2, 30));
            end else if (r < 85) begin
                // Noise: any mode, long durations only past the pending list
                repeat ($urandom_range(1, 4)) begin
                    ix = IDX_W'($urandom);
                    cl = LEN_W'($urandom);
                    md = MODE_W'($urandom_range(0, 3));
                    d = (ix >= gen_pend_len) ? $urandom : $urandom_range(0, 12);
                    if (md == MODE_COMMIT && !list_ok(cl))
                        md = MODE_TICK;
                    push_item(md, ix, GATE_W'($urandom), d, cl, 1'($urandom));
                end
            end else if ($urandom_range(0, 1)) begin
                // Broken: a few writes with no commit of their own
                repeat ($urandom_range(1, 3))
                    push_item(MODE_WRITE, IDX_W'($urandom), GATE_W'($urandom),
                              $urandom_range(1, 4), LEN_W'($urandom), 1'($urandom));
            end else begin
                // Broken: commit whatever is there, no fresh writes
                cl = LEN_W'($urandom);
                if (!list_ok(cl))
                    cl = '0;
                push_item(MODE_COMMIT, IDX_W'($urandom), GATE_W'($urandom), $urandom, cl,
                          1'($urandom));
                push_ticks($urandom_range(1, 12));
            end
        end
        drain();
    endtask

    initial begin : stimulus
        int k;
        for (k = 0; k < LIST_DEPTH; k++) begin
            sch_act_gates[k] = '0;
            sch_act_dur[k] = '0;
            sch_pend_gates[k] = '0;
            sch_pend_dur[k] = '0;
            gen_written[k] = 1'b0;
            gen_big[k] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle ticks, unused mode, empty list, one full cycle
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        set_config(8'h0F, 1'b1, 16'd3);
        push_item(MODE_TICK, '0, '0, '0, '0, 1'b1);
        push_item(MODE_SPARE, '1, '1, '1, '1, 1'b1);
        push_item(MODE_COMMIT, '0, '0, '0, '0, 1'b0);
        push_item(MODE_TICK, '0, '0, '0, '0, 1'b1);
        push_item(MODE_TICK, '0, '0, '0, '0, 1'b0);
        push_item(MODE_WRITE, 4'd0, 8'h00, 32'd0, '0, 1'b0);
        push_item(MODE_WRITE, 4'd1, 8'hFF, 32'd1, '0, 1'b0);
        push_item(MODE_WRITE, 4'd2, 8'hF0, 32'd7, '0, 1'b0);
        push_item(MODE_WRITE, 4'd3, 8'h0F, 32'd3, '0, 1'b0);
        push_item(MODE_WRITE, 4'd15, 8'hAA, 32'hFFFF_FFFF, '1, 1'b1);
        push_item(MODE_COMMIT, '0, '0, '0, 5'd4, 1'b0);
        for (k = 0; k < 9; k++)
            push_item(MODE_TICK, '0, '0, '0, '0, k[0]);
        // Empty list behind the running one: no hold on its last entry
        push_item(MODE_COMMIT, '0, '0, '0, '0, 1'b1);
        for (k = 0; k < 5; k++)
            push_item(MODE_TICK, '0, '0, '0, '0, 1'b1);
        drain();

        // Random phases over several register settings
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        set_config(GATE_W'($urandom), 1'b0, ADV_W'($urandom));
        run_phase(175);

        rx_idle_pct = 20;
        set_config(8'hFF, 1'b1, 16'd0);
        rx_long_arm = 1'b1;
        run_phase(175);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(GATE_W'($urandom), 1'b1, 16'hFFFF);
        run_phase(175);

        tx_idle_pct = 30;
        rx_idle_pct = 30;
        set_config(GATE_W'($urandom), 1'b1, ADV_W'($urandom_range(0, 6)));
        run_phase(175);

        set_config(8'h00, 1'b1, ADV_W'($urandom));
        run_phase(175);

        // Run down to idle, then an entry with the longest duration
        set_config(8'h81, 1'b1, 16'hFFFF);
        push_item(MODE_COMMIT, IDX_W'($urandom), GATE_W'($urandom), $urandom, '0,
                  1'($urandom));
        k = 0;
        do begin
            push_ticks(16);
            drain();
            k++;
        end while ((sch_run || sch_pend_ok) && k < 40);
        push_item(MODE_WRITE, 4'd0, 8'h01, 32'hFFFF_FFFF, '0, 1'b0);
        push_item(MODE_WRITE, 4'd1, 8'h80, 32'd2, '0, 1'b0);
        push_item(MODE_COMMIT, '0, '0, '0, 5'd2, 1'b1);
        push_ticks(6);
        drain();

        if (err_cnt == 0)
            $display("tsn_gate_control_list_sequencer_core_tb: clean");
        else
            $display("tsn_gate_control_list_sequencer_core_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tgcl_pkg.sv
hw/rtl/tgcl_list_store.sv
hw/rtl/tgcl_sched.sv
hw/rtl/tsn_gate_control_list_sequencer_core.sv
verif/tsn_gate_control_list_sequencer_core_tb.sv
